// File: rtl/bc4_pkg.sv
// bc4_pkg: shared types, constants and palette helpers for the bc4 block encoder
// used by every module of the encoder pipeline; no dependencies
`default_nettype none

package bc4_pkg;

  localparam int PixelsPerBlock = 16;
  localparam int IndexBits      = 3;
  localparam int PaletteSize    = 8;
  localparam int ErrorWidth     = 20;
  localparam int SqWidth        = 16;

  // reciprocals for floor division by 7 and by 5, exact for sums up to 7 * 255
  localparam int           RecipShift = 16;
  localparam logic [13:0]  Div7Mul    = 14'd9363;
  localparam logic [13:0]  Div5Mul    = 14'd13108;
  localparam logic [7:0]   FixedLow   = 8'h00;
  localparam logic [7:0]   FixedHigh  = 8'hFF;

  typedef logic [PaletteSize-1:0][7:0]         palette_t;
  typedef logic [PaletteSize-1:0][SqWidth-1:0] err_vec_t;

  // position of an item within its block
  typedef struct packed {
    logic first;
    logic last;
  } pix_ctl_t;

  // stage 1 payload: endpoints in force for this pixel
  typedef struct packed {
    logic [15:0] endpoints;
    logic [7:0]  pixel;
    pix_ctl_t    ctl;
  } in_stage_t;

  // stage 2 payload: palette built from the endpoints
  typedef struct packed {
    logic [15:0] endpoints;
    logic [7:0]  pixel;
    palette_t    palette;
    pix_ctl_t    ctl;
  } pal_stage_t;

  // stage 3 payload: squared error against every palette entry
  typedef struct packed {
    logic [15:0] endpoints;
    err_vec_t    errors;
    pix_ctl_t    ctl;
  } err_stage_t;

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [24:0] prod;
    prod = 25'(x) * 25'(Div7Mul);
    return prod[RecipShift+7:RecipShift];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [24:0] prod;
    prod = 25'(x) * 25'(Div5Mul);
    return prod[RecipShift+7:RecipShift];
  endfunction

  function automatic palette_t build_palette(input logic [7:0] e0, input logic [7:0] e1);
    palette_t    p;
    logic [10:0] s;
    p    = '0;
    p[0] = e0;
    p[1] = e1;
    if (e0 > e1) begin
      for (int k = 1; k <= 6; k++) begin
        s = 11'(7 - k) * {3'b000, e0} + 11'(k) * {3'b000, e1};
        p[k+1] = div7(s);
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        s = 11'(5 - k) * {3'b000, e0} + 11'(k) * {3'b000, e1};
        p[k+1] = div5(s);
      end
      p[6] = FixedLow;
      p[7] = FixedHigh;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bc4_input_stage.sv
// bc4_input_stage: pixel position counter, endpoint latch and input register
// depends on bc4_pkg
`default_nettype none

module bc4_input_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [15:0]          in_endpoints,
  input  wire logic [7:0]           in_pixel,
  input  wire logic                 en,
  output logic                      out_valid,
  output bc4_pkg::in_stage_t        out_data
);

  logic [3:0]  pixel_count;
  logic [15:0] latched_endpoints;
  logic        first_pixel;
  logic        accept;

  assign first_pixel = (pixel_count == 4'd0);
  assign accept      = in_valid && en;

  // position counter and endpoint latch, taken on the first pixel of a block
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count       <= 4'd0;
      latched_endpoints <= 16'd0;
    end else if (accept) begin
      pixel_count <= pixel_count + 4'd1;
      if (first_pixel) begin
        latched_endpoints <= in_endpoints;
      end
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.endpoints <= first_pixel ? in_endpoints : latched_endpoints;
      out_data.pixel     <= in_pixel;
      out_data.ctl.first <= first_pixel;
      out_data.ctl.last  <= (pixel_count == 4'(bc4_pkg::PixelsPerBlock - 1));
    end
  end

endmodule

`default_nettype wire

// File: rtl/bc4_palette_stage.sv
// bc4_palette_stage: builds the eight-entry palette from the block endpoints
// depends on bc4_pkg
`default_nettype none

module bc4_palette_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire bc4_pkg::in_stage_t   in_data,
  input  wire logic                 en,
  output logic                      out_valid,
  output bc4_pkg::pal_stage_t       out_data
);

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // palette from endpoint0 (low byte) and endpoint1 (high byte)
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.endpoints <= in_data.endpoints;
      out_data.pixel     <= in_data.pixel;
      out_data.palette   <= bc4_pkg::build_palette(in_data.endpoints[7:0],
                                                   in_data.endpoints[15:8]);
      out_data.ctl       <= in_data.ctl;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bc4_error_stage.sv
// bc4_error_stage: squared error of the pixel against each palette entry
// depends on bc4_pkg
`default_nettype none

module bc4_error_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire bc4_pkg::pal_stage_t  in_data,
  input  wire logic                 en,
  output logic                      out_valid,
  output bc4_pkg::err_stage_t       out_data
);

  bc4_pkg::err_vec_t errors;

  // absolute difference squared, one lane per entry
  always_comb begin
    logic [7:0] diff;
    diff   = '0;
    errors = '0;
    for (int i = 0; i < bc4_pkg::PaletteSize; i++) begin
      diff = (in_data.pixel >= in_data.palette[i]) ? (in_data.pixel - in_data.palette[i])
                                                   : (in_data.palette[i] - in_data.pixel);
      errors[i] = {8'd0, diff} * {8'd0, diff};
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.endpoints <= in_data.endpoints;
      out_data.errors    <= errors;
      out_data.ctl       <= in_data.ctl;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bc4_accumulate.sv
// bc4_accumulate: best-index pick, index and error accumulation, result register
// depends on bc4_pkg
`default_nettype none

module bc4_accumulate (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire bc4_pkg::err_stage_t  in_data,
  output logic                      take,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic [63:0]               res_block_bits,
  output logic [19:0]               res_total_error
);

  localparam int IdxAccWidth = bc4_pkg::IndexBits * (bc4_pkg::PixelsPerBlock - 1);

  logic [IdxAccWidth-1:0]          index_accumulator;
  logic [bc4_pkg::ErrorWidth-1:0]  error_accumulator;
  logic [bc4_pkg::ErrorWidth-1:0]  error_sum;

  logic [3:0][bc4_pkg::SqWidth-1:0] l1_err;
  logic [3:0][0:0]                  l1_idx;
  logic [1:0][bc4_pkg::SqWidth-1:0] l2_err;
  logic [1:0][1:0]                  l2_idx;
  logic [bc4_pkg::SqWidth-1:0]      best_err;
  logic [2:0]                       best_idx;

  // argmin tree, the left (lower) index wins on a tie
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (in_data.errors[2*j+1] < in_data.errors[2*j]) begin
        l1_err[j] = in_data.errors[2*j+1];
        l1_idx[j] = 1'b1;
      end else begin
        l1_err[j] = in_data.errors[2*j];
        l1_idx[j] = 1'b0;
      end
    end
    for (int j = 0; j < 2; j++) begin
      if (l1_err[2*j+1] < l1_err[2*j]) begin
        l2_err[j] = l1_err[2*j+1];
        l2_idx[j] = {1'b1, l1_idx[2*j+1]};
      end else begin
        l2_err[j] = l1_err[2*j];
        l2_idx[j] = {1'b0, l1_idx[2*j]};
      end
    end
    if (l2_err[1] < l2_err[0]) begin
      best_err = l2_err[1];
      best_idx = {1'b1, l2_idx[1]};
    end else begin
      best_err = l2_err[0];
      best_idx = {1'b0, l2_idx[0]};
    end
  end

  // running error, restarted on the first pixel of a block
  assign error_sum = (in_data.ctl.first ? '0 : error_accumulator)
                   + bc4_pkg::ErrorWidth'(best_err);

  // the last pixel waits only while the previous result is still held
  assign take = in_valid && !(in_data.ctl.last && res_valid && !res_ready);

  // accumulators: indices shift in from the top, pixel 0 ends in the low bits
  always_ff @(posedge clk) begin
    if (rst) begin
      index_accumulator <= '0;
      error_accumulator <= '0;
    end else if (take && !in_data.ctl.last) begin
      index_accumulator <= {best_idx, index_accumulator[IdxAccWidth-1:bc4_pkg::IndexBits]};
      error_accumulator <= error_sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && in_data.ctl.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_data.ctl.last) begin
      res_block_bits  <= {best_idx, index_accumulator, in_data.endpoints};
      res_total_error <= error_sum;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bc4_block_index_encoder.sv
// bc4_block_index_encoder: top level of the bc4 (rgtc1) block index encoder
// depends on bc4_pkg and the four stage modules
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  endpoint_zero, endpoint_one, pixel_value
//   m_*       out   m_tvalid/m_tready  block_bits, total_error
//
// one pixel item per cycle, sustained unless a held result stalls the pipeline; the first pixel of a block is the one
// after reset or after every sixteenth item
// a block's last pixel reaches its result through the input register,
// palette register, error register and result register
// reset clears the pixel position, the endpoint latch, the accumulators and
// the valid flags
// a held result stalls the sixteenth pixel of the next block and the items behind it;
// items before it keep flowing into the pipeline
`default_nettype none

module bc4_block_index_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // endpoint_zero [7:0], endpoint_one [15:8],
                                     // pixel_value [23:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata   // block_bits [63:0], total_error [83:64],
                                     // zero [87:84]
);

  logic                 s1_valid, s2_valid, s3_valid;
  logic                 en1, en2, en3, take;
  bc4_pkg::in_stage_t   s1_data;
  bc4_pkg::pal_stage_t  s2_data;
  bc4_pkg::err_stage_t  s3_data;
  logic [63:0]          block_bits;
  logic [19:0]          total_error;

  // a stage loads when it is empty or its content moves on
  assign en3      = !s3_valid || take;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign s_tready = en1;

  bc4_input_stage u_input (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_endpoints (s_tdata[15:0]),
    .in_pixel     (s_tdata[23:16]),
    .en           (en1),
    .out_valid    (s1_valid),
    .out_data     (s1_data)
  );

  bc4_palette_stage u_palette (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .en        (en2),
    .out_valid (s2_valid),
    .out_data  (s2_data)
  );

  bc4_error_stage u_error (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_data   (s2_data),
    .en        (en3),
    .out_valid (s3_valid),
    .out_data  (s3_data)
  );

  bc4_accumulate u_accumulate (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s3_valid),
    .in_data         (s3_data),
    .take            (take),
    .res_valid       (m_tvalid),
    .res_ready       (m_tready),
    .res_block_bits  (block_bits),
    .res_total_error (total_error)
  );

  // output packing
  assign m_tdata = {4'd0, total_error, block_bits};

endmodule

`default_nettype wire

// File: test/tb_bc4_block_index_encoder.sv
`timescale 1ns / 1ps
// tb_bc4_block_index_encoder: self-checking bench for the bc4 block index encoder
// streams pixel blocks with random stalls on both sides and scores every result
// against a behavioral palette and index predictor; depends on bc4_pkg and the rtl

module tb_bc4_block_index_encoder;

  localparam int CycleLimit   = 200000;
  localparam int RandomBlocks = 76;
  localparam int TailCycles   = 8;

  typedef struct {
    logic [63:0] bits;
    logic [19:0] err;
  } block_result_t;

  // one directed block: endpoints, sixteen pixels (pixel i in byte i), optional known result
  typedef struct {
    logic [7:0]   ep0;
    logic [7:0]   ep1;
    logic [127:0] pixels;
    bit           given;
    logic [63:0]  bits;
    logic [19:0]  err;
  } block_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;

  // predictor state
  int            pixel_pos = 0;
  logic [15:0]   ep_word = '0;
  logic [47:0]   index_word = '0;
  logic [19:0]   sq_err_sum = '0;
  block_result_t pending_blocks[$];
  bit            given_valid = 1'b0;
  block_result_t given_res;

  // bookkeeping
  bit            calm = 1'b0;
  int            mismatches = 0;
  int            blocks_checked = 0;
  int            equal_blocks = 0;
  int            pixels_sent = 0;
  int            cycle_count = 0;
  block_result_t want;
  bit            bad;
  block_row_t    plan[2];

  bc4_block_index_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // eight palette levels from the two endpoints
  function automatic bc4_pkg::palette_t build_levels(input logic [7:0] ep_a,
                                                     input logic [7:0] ep_b);
    bc4_pkg::palette_t lv;
    int                a;
    int                b;
    a     = int'(ep_a);
    b     = int'(ep_b);
    lv    = '0;
    lv[0] = ep_a;
    lv[1] = ep_b;
    if (a > b) begin
      for (int k = 1; k <= 6; k++) lv[k+1] = 8'(((7 - k) * a + k * b) / 7);
    end else begin
      for (int k = 1; k <= 4; k++) lv[k+1] = 8'(((5 - k) * a + k * b) / 5);
      lv[6] = 8'h00;
      lv[7] = 8'hFF;
    end
    return lv;
  endfunction

  // advance the predicted encoder by one accepted pixel
  function automatic void encode_pixel(input logic [7:0] e0, input logic [7:0] e1,
                                       input logic [7:0] pix);
    bc4_pkg::palette_t lv;
    int                d;
    int                sq;
    int                best_sq;
    logic [2:0]        best_idx;
    block_result_t     res;
    if (pixel_pos == 0) begin
      ep_word    = {e1, e0};
      index_word = '0;
      sq_err_sum = '0;
    end
    lv       = build_levels(ep_word[7:0], ep_word[15:8]);
    best_idx = 3'd0;
    d        = int'(pix) - int'(lv[0]);
    best_sq  = d * d;
    // strict compare keeps the lowest index on a tie
    for (int i = 1; i < bc4_pkg::PaletteSize; i++) begin
      d  = int'(pix) - int'(lv[i]);
      sq = d * d;
      if (sq < best_sq) begin
        best_sq  = sq;
        best_idx = 3'(i);
      end
    end
    sq_err_sum = sq_err_sum + 20'(best_sq);
    index_word[3*pixel_pos +: 3] = best_idx;
    if (pixel_pos == bc4_pkg::PixelsPerBlock - 1) begin
      res.bits = {index_word, ep_word};
      res.err  = sq_err_sum;
      if (given_valid) res = given_res;
      pending_blocks.push_back(res);
      if (ep_word[7:0] == ep_word[15:8]) equal_blocks++;
      pixel_pos = 0;
    end else begin
      pixel_pos++;
    end
  endfunction

  // offer one pixel item, with random idle cycles ahead of it
  task automatic send_pixel(input logic [7:0] e0, input logic [7:0] e1, input logic [7:0] pix);
    while (!calm && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pix, e1, e0};
    do @(posedge clk); while (!s_tready);
    encode_pixel(e0, e1, pix);
    pixels_sent++;
  endtask

  // hold the sender off until every pending block has come out
  task automatic drain_blocks();
    s_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
  endtask

  // pixel near a palette level, a rail value, or anything
  function automatic logic [7:0] pick_pixel(input bc4_pkg::palette_t lv);
    int v;
    case ($urandom_range(3))
      2: v = $urandom_range(1) ? 255 : 0;
      3: begin
        v = int'(lv[$urandom_range(7)]) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: v = $urandom_range(255);
    endcase
    return 8'(v);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 23);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected block result %h", m_tdata);
      end else begin
        want = pending_blocks.pop_front();
        bad  = 1'b0;
        if (m_tdata[63:0] !== want.bits) begin
          bad = 1'b1;
          if (mismatches < 10)
            $display("block %0d bits: expected %h, got %h", blocks_checked, want.bits,
                     m_tdata[63:0]);
        end
        if (m_tdata[83:64] !== want.err) begin
          bad = 1'b1;
          if (mismatches < 10)
            $display("block %0d error sum: expected %0d, got %0d", blocks_checked, want.err,
                     m_tdata[83:64]);
        end
        if (bad) mismatches++;
        blocks_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [7:0]        e0;
    logic [7:0]        e1;
    bc4_pkg::palette_t lv;

    // low endpoint then high: every pixel at 255 ties index 1 with the fixed 255 entry
    plan[0] = '{8'h00, 8'hFF, {16{8'hFF}}, 1'b1, 64'h2492_4924_9249_FF00, 20'd0};
    // descending endpoints, rail pixels and values around the seventh steps
    plan[1] = '{8'hFF, 8'h00, 128'h55AA_DBDA_B691_6D49_2524_807F_FE01_FF00, 1'b0, 64'h0, 20'd0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed blocks; endpoints on later pixels are inverted and must be ignored
    foreach (plan[r]) begin
      given_valid = plan[r].given;
      given_res   = '{plan[r].bits, plan[r].err};
      for (int p = 0; p < bc4_pkg::PixelsPerBlock; p++) begin
        if (p == 0) send_pixel(plan[r].ep0, plan[r].ep1, plan[r].pixels[8*p +: 8]);
        else send_pixel(~plan[r].ep0, ~plan[r].ep1, plan[r].pixels[8*p +: 8]);
      end
      given_valid = 1'b0;
    end
    drain_blocks();

    // random blocks, one stretch with no idling on either side
    for (int b = 0; b < RandomBlocks; b++) begin
      calm = (b >= 30 && b < 42);
      if (b == 55) drain_blocks();
      case ($urandom_range(7))
        0: begin
          e0 = 8'($urandom_range(255));
          e1 = e0;
        end
        1: begin
          e0 = $urandom_range(1) ? 8'hFF : 8'h00;
          e1 = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        default: begin
          e0 = 8'($urandom_range(255));
          e1 = 8'($urandom_range(255));
        end
      endcase
      lv = build_levels(e0, e1);
      send_pixel(e0, e1, pick_pixel(lv));
      for (int p = 1; p < bc4_pkg::PixelsPerBlock; p++)
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), pick_pixel(lv));
    end
    calm = 1'b0;
    drain_blocks();
    repeat (TailCycles) @(posedge clk);

    $display("sent %0d pixel items in %0d blocks, %0d results checked", pixels_sent,
             pixels_sent / bc4_pkg::PixelsPerBlock, blocks_checked);
    $display("%0d blocks used equal endpoints, %0d mismatches", equal_blocks, mismatches);
    if (mismatches == 0 && pending_blocks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
